FILE: rtl/bffd_pkg.sv
//------------------------------------------------------------------------------
// bffd_pkg
// Types, register indexes and constants shared by the body force step block.
//------------------------------------------------------------------------------
package bffd_pkg;

  localparam int unsigned NumRegs = 7;
  localparam int unsigned RegIdxW = 3;

  localparam logic [RegIdxW-1:0] RegBodyMass  = 3'd0;
  localparam logic [RegIdxW-1:0] RegGravity   = 3'd1;
  localparam logic [RegIdxW-1:0] RegFriction  = 3'd2;
  localparam logic [RegIdxW-1:0] RegDensity   = 3'd3;
  localparam logic [RegIdxW-1:0] RegDragCoeff = 3'd4;
  localparam logic [RegIdxW-1:0] RegArea      = 3'd5;
  localparam logic [RegIdxW-1:0] RegStopThr   = 3'd6;

  localparam logic [31:0] MassReset     = 32'd65536;
  localparam logic [31:0] GravityReset  = 32'd642908;
  localparam logic [31:0] StopThrReset  = 32'd655;

  typedef struct packed {
    logic [31:0]        step_time;
    logic signed [31:0] force_x;
    logic signed [31:0] force_y;
    logic signed [31:0] force_z;
  } bffd_in_t;

  typedef struct packed {
    logic               moving;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] vel_z;
  } bffd_out_t;

  typedef struct packed {
    logic [31:0] body_mass;
    logic [31:0] gravity_accel;
    logic [31:0] kinetic_friction;
    logic [31:0] fluid_density;
    logic [31:0] drag_coeff;
    logic [31:0] frontal_area;
    logic [31:0] stop_threshold;
  } bffd_cfg_t;

  // datapath operations issued by the controller
  typedef enum logic [3:0] {
    OpNone,
    OpLoad,      // latch dt, force, pick mass
    OpForce,     // start force division for lane
    OpForceWb,   // write back force result for lane
    OpSqAcc,     // accumulate v_i^2 for lane
    OpSqrt,      // start square root
    OpSqrtWb,    // latch |v|
    OpMulq,      // one saturating Q16.16 product step
    OpTakeDiv,   // start |v_i|*r/|v| or |v_i|*d/|v| division for lane
    OpTakeWb,    // apply take-along result for lane
    OpDragDiv,   // start (t<<16)/mass
    OpDragWb,    // latch drag amount
    OpStop,      // zero velocity
    OpPos,       // integrate position for lane
    OpMoveSet    // set moving flag
  } bffd_op_e;

  typedef struct packed {
    bffd_op_e    op;
    logic [1:0]  lane;
    logic [2:0]  mul_sel;   // which mulq step
    logic        fric;      // take-along uses friction amount
  } bffd_cmd_t;

  typedef struct packed {
    logic unit_busy;
    logic moving;    // some |v_i| >= threshold
    logic mag_zero;
  } bffd_sts_t;

  localparam logic [2:0] MulGmu   = 3'd0;
  localparam logic [2:0] MulRdt   = 3'd1;
  localparam logic [2:0] MulVV    = 3'd2;
  localparam logic [2:0] MulRho   = 3'd3;
  localparam logic [2:0] MulCd    = 3'd4;
  localparam logic [2:0] MulArea  = 3'd5;
  localparam logic [2:0] MulDt    = 3'd6;

endpackage

FILE: rtl/bffd_divsqrt.sv
//------------------------------------------------------------------------------
// bffd_divsqrt
// Shared iterative unit: 66/64-bit restoring divide or 64-bit integer sqrt,
// one quotient/root bit per cycle.
//------------------------------------------------------------------------------
module bffd_divsqrt import bffd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_div_i,
  input  logic        start_sqrt_i,
  input  logic [65:0] num_i,
  input  logic [63:0] den_i,
  output logic        busy_o,
  output logic [65:0] res_o
);
  logic [6:0]  cnt_q, cnt_d;
  logic        sq_q, sq_d;
  logic [65:0] quo_q, quo_d;
  logic [64:0] rem_q, rem_d;
  logic [63:0] den_q, den_d;
  logic [65:0] rad_q, rad_d;
  logic [64:0] trial;
  logic [66:0] sq_trial;
  logic [65:0] rem_sh;

  always_comb begin
    cnt_d = cnt_q; sq_d = sq_q; quo_d = quo_q; rem_d = rem_q;
    den_d = den_q; rad_d = rad_q;
    trial = '0; sq_trial = '0; rem_sh = '0;
    if (start_div_i) begin
      cnt_d = 7'd66; sq_d = 1'b0; quo_d = num_i; rem_d = '0; den_d = den_i;
    end else if (start_sqrt_i) begin
      cnt_d = 7'd32; sq_d = 1'b1; quo_d = '0; rem_d = '0; rad_d = num_i;
    end else if (cnt_q != 7'd0) begin
      cnt_d = cnt_q - 7'd1;
      if (!sq_q) begin
        rem_sh = {rem_q[64:0], quo_q[65]};
        trial  = rem_sh[64:0] - {1'b0, den_q};
        quo_d  = {quo_q[64:0], 1'b0};
        if (rem_sh >= {2'b0, den_q}) begin
          rem_d = trial; quo_d[0] = 1'b1;
        end else begin
          rem_d = rem_sh[64:0];
        end
      end else begin
        // digit-by-digit root: remainder gets next two radicand bits
        rem_sh   = {rem_q[63:0], rad_q[63:62]};
        sq_trial = {1'b0, rem_sh} - {quo_q[63:0], 2'b01};
        rad_d    = {rad_q[63:0], 2'b00};
        if (!sq_trial[66]) begin
          rem_d = sq_trial[64:0]; quo_d = {quo_q[64:0], 1'b1};
        end else begin
          rem_d = rem_sh[64:0]; quo_d = {quo_q[64:0], 1'b0};
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      sq_q  <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      sq_q  <= sq_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d; rem_q <= rem_d; den_q <= den_d; rad_q <= rad_d;
  end

  assign busy_o = (cnt_q != 7'd0);
  assign res_o  = quo_q;
endmodule

FILE: rtl/bffd_datapath.sv
//------------------------------------------------------------------------------
// bffd_datapath
// Velocity/position state, a combinational 32x32 multiplier and
// the shared divide/sqrt unit.
//------------------------------------------------------------------------------
module bffd_datapath import bffd_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  bffd_cmd_t cmd_i,
  input  bffd_in_t  in_i,
  input  bffd_cfg_t cfg_i,
  output bffd_sts_t sts_o,
  output bffd_out_t res_o
);
  logic signed [31:0] vel_q [3];
  logic signed [31:0] pos_q [3];
  logic [31:0] dt_q, fm_q [3];
  logic        fneg_q [3];
  logic [31:0] mass_q, mag_q, r_q, t_q, d_q;
  logic [65:0] sum_q;
  logic        moving_q;

  logic [31:0] vm [3];
  logic [31:0] vml;
  logic        vneg;
  logic [31:0] ma, mb;
  logic [63:0] prod;
  logic [47:0] prod_sh;
  logic [31:0] mulq_sat;
  logic        start_div, start_sqrt, busy;
  logic [65:0] num, qres;
  logic [63:0] den;
  logic signed [34:0] acc;
  logic [33:0] qclip;
  logic [31:0] fm_in [3];
  logic [31:0] amount;
  logic [31:0] pos_step;

  function automatic logic signed [31:0] sat32(input logic signed [34:0] v);
    if (v > 35'sd2147483647)       return 32'sh7fffffff;
    else if (v < -35'sd2147483648) return 32'sh80000000;
    else                           return v[31:0];
  endfunction

  always_comb begin
    for (int i = 0; i < 3; i++) vm[i] = vel_q[i][31] ? (32'd0 - vel_q[i]) : vel_q[i];
  end
  assign fm_in[0] = in_i.force_x[31] ? (32'd0 - in_i.force_x) : in_i.force_x;
  assign fm_in[1] = in_i.force_y[31] ? (32'd0 - in_i.force_y) : in_i.force_y;
  assign fm_in[2] = in_i.force_z[31] ? (32'd0 - in_i.force_z) : in_i.force_z;

  assign vml  = vm[cmd_i.lane];
  assign vneg = vel_q[cmd_i.lane][31];
  assign amount = cmd_i.fric ? r_q : d_q;

  // multiplier operand selection
  always_comb begin
    ma = vml; mb = vml;
    unique case (cmd_i.op)
      OpMulq: begin
        unique case (cmd_i.mul_sel)
          MulGmu:  begin ma = cfg_i.gravity_accel; mb = cfg_i.kinetic_friction; end
          MulRdt:  begin ma = t_q; mb = dt_q; end
          MulVV:   begin ma = mag_q; mb = mag_q; end
          MulRho:  begin ma = t_q; mb = cfg_i.fluid_density; end
          MulCd:   begin ma = t_q; mb = cfg_i.drag_coeff; end
          MulArea: begin ma = t_q; mb = cfg_i.frontal_area; end
          MulDt:   begin ma = {1'b0, t_q[31:1]}; mb = dt_q; end
          default: begin ma = t_q; mb = dt_q; end
        endcase
      end
      OpForce:   begin ma = fm_q[cmd_i.lane]; mb = dt_q; end
      OpTakeDiv: begin ma = vml; mb = amount; end
      OpPos:     begin ma = vml; mb = dt_q; end
      default:   begin ma = vml; mb = vml; end
    endcase
  end
  assign prod     = {32'd0, ma} * {32'd0, mb};
  assign prod_sh  = prod[63:16];
  assign mulq_sat = (prod_sh[47:32] != 16'd0) ? 32'hffffffff : prod_sh[31:0];

  // position step (|v|*dt)>>16; anything past 32 bits saturates the sum anyway
  assign pos_step = (prod[63:48] != 16'd0) ? 32'hffffffff : prod[47:16];

  assign start_div  = (cmd_i.op == OpForce) || (cmd_i.op == OpTakeDiv) ||
                      (cmd_i.op == OpDragDiv);
  assign start_sqrt = (cmd_i.op == OpSqrt);
  always_comb begin
    num = {2'b0, prod}; den = {32'd0, mass_q};
    unique case (cmd_i.op)
      OpTakeDiv: begin num = {2'b0, prod}; den = {32'd0, mag_q}; end
      OpDragDiv: begin num = {18'd0, t_q, 16'd0}; den = {32'd0, mass_q}; end
      OpSqrt:    begin num = sum_q; den = {32'd0, mass_q}; end
      default:   begin num = {2'b0, prod}; den = {32'd0, mass_q}; end
    endcase
  end

  bffd_divsqrt u_unit (
    .clk_i, .rst_ni,
    .start_div_i (start_div),
    .start_sqrt_i(start_sqrt),
    .num_i       (num),
    .den_i       (den),
    .busy_o      (busy),
    .res_o       (qres)
  );

  assign qclip = (qres[65:34] != 32'd0 || qres[33:0] > 34'h200000000) ?
                 34'h200000000 : qres[33:0];

  // signed update before saturation for the write-back operations
  always_comb begin
    acc = '0;
    unique case (cmd_i.op)
      OpForceWb: begin
        acc = fneg_q[cmd_i.lane] ? ($signed({{3{vel_q[cmd_i.lane][31]}}, vel_q[cmd_i.lane]})
               - $signed({1'b0, qclip}))
            : ($signed({{3{vel_q[cmd_i.lane][31]}}, vel_q[cmd_i.lane]})
               + $signed({1'b0, qclip}));
      end
      OpTakeWb: begin
        acc = vneg ? ($signed({{3{vel_q[cmd_i.lane][31]}}, vel_q[cmd_i.lane]})
               + $signed({1'b0, qres[33:0]}))
            : ($signed({{3{vel_q[cmd_i.lane][31]}}, vel_q[cmd_i.lane]})
               - $signed({1'b0, qres[33:0]}));
      end
      OpPos: begin
        acc = vneg ? ($signed({{3{pos_q[cmd_i.lane][31]}}, pos_q[cmd_i.lane]})
               - $signed({3'b0, pos_step}))
            : ($signed({{3{pos_q[cmd_i.lane][31]}}, pos_q[cmd_i.lane]})
               + $signed({3'b0, pos_step}));
      end
      default: acc = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 3; i++) begin
        vel_q[i] <= '0;
        pos_q[i] <= '0;
      end
      moving_q <= 1'b0;
    end else begin
      unique case (cmd_i.op)
        OpLoad: begin
          dt_q   <= in_i.step_time;
          mass_q <= (cfg_i.body_mass == 32'd0) ? 32'd1 : cfg_i.body_mass;
          for (int i = 0; i < 3; i++) fm_q[i] <= fm_in[i];
          fneg_q[0] <= in_i.force_x[31];
          fneg_q[1] <= in_i.force_y[31];
          fneg_q[2] <= in_i.force_z[31];
          sum_q <= '0;
        end
        OpForceWb: begin
          vel_q[cmd_i.lane] <= sat32(acc);
          sum_q <= '0;
        end
        OpSqAcc:  sum_q <= sum_q + {2'b0, prod};
        OpSqrtWb: begin
          mag_q <= qres[31:0];
          sum_q <= '0;
        end
        OpMulq: begin
          t_q <= mulq_sat;
          if (cmd_i.mul_sel == MulRdt) r_q <= (mulq_sat > mag_q) ? mag_q : mulq_sat;
        end
        OpTakeWb: vel_q[cmd_i.lane] <= sat32(acc);
        OpDragWb: d_q <= (qres[65:32] != 34'd0) ? 32'hffffffff : qres[31:0];
        OpStop: begin
          for (int i = 0; i < 3; i++) vel_q[i] <= '0;
          moving_q <= 1'b0;
        end
        OpPos:     pos_q[cmd_i.lane] <= sat32(acc);
        OpMoveSet: moving_q <= 1'b1;
        default: ;
      endcase
    end
  end

  assign sts_o.unit_busy = busy;
  assign sts_o.moving    = (vm[0] >= cfg_i.stop_threshold) ||
                           (vm[1] >= cfg_i.stop_threshold) ||
                           (vm[2] >= cfg_i.stop_threshold);
  assign sts_o.mag_zero  = (mag_q == 32'd0);

  assign res_o.moving = moving_q;
  assign res_o.pos_x  = pos_q[0];
  assign res_o.pos_y  = pos_q[1];
  assign res_o.pos_z  = pos_q[2];
  assign res_o.vel_x  = vel_q[0];
  assign res_o.vel_y  = vel_q[1];
  assign res_o.vel_z  = vel_q[2];
endmodule

FILE: rtl/bffd_ctrl.sv
//------------------------------------------------------------------------------
// bffd_ctrl
// Sequencer: force, friction, drag, integrate; one transaction at a time.
//------------------------------------------------------------------------------
module bffd_ctrl import bffd_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  input  bffd_sts_t sts_i,
  output bffd_cmd_t cmd_o
);
  typedef enum logic [4:0] {
    SIdle, SForce, SForceW, SFricChk, SSq, SSqrt, SSqrtW, SMul, STake, STakeW,
    SDragDiv, SDragW, SFinal, SPos, SOut
  } state_e;

  state_e     state_q;
  logic [1:0] lane_q;
  logic [2:0] mul_q;
  logic       fric_q;   // 1 while in friction phase

  assign in_stall_o  = (state_q != SIdle);
  assign out_valid_o = (state_q == SOut);

  always_comb begin
    cmd_o = '{op: OpNone, lane: lane_q, mul_sel: mul_q, fric: fric_q};
    unique case (state_q)
      SIdle:    if (in_valid_i) cmd_o.op = OpLoad;
      SForce:   cmd_o.op = OpForce;
      SForceW:  if (!sts_i.unit_busy) cmd_o.op = OpForceWb;
      SSq:      cmd_o.op = OpSqAcc;
      SSqrt:    cmd_o.op = OpSqrt;
      SSqrtW:   if (!sts_i.unit_busy) cmd_o.op = OpSqrtWb;
      SMul:     cmd_o.op = OpMulq;
      STake:    cmd_o.op = OpTakeDiv;
      STakeW:   if (!sts_i.unit_busy) cmd_o.op = OpTakeWb;
      SDragDiv: cmd_o.op = OpDragDiv;
      SDragW:   if (!sts_i.unit_busy) cmd_o.op = OpDragWb;
      SFinal:   cmd_o.op = sts_i.moving ? OpMoveSet : OpStop;
      SPos:     cmd_o.op = OpPos;
      default:  cmd_o.op = OpNone;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
      lane_q  <= '0;
      mul_q   <= '0;
      fric_q  <= 1'b0;
    end else begin
      unique case (state_q)
        SIdle: if (in_valid_i) begin
          state_q <= SForce; lane_q <= '0;
        end
        SForce:  state_q <= SForceW;
        SForceW: if (!sts_i.unit_busy) begin
          if (lane_q == 2'd2) begin
            state_q <= SFricChk; fric_q <= 1'b1;
          end else begin
            lane_q <= lane_q + 2'd1; state_q <= SForce;
          end
        end
        SFricChk: begin
          lane_q <= '0;
          state_q <= sts_i.moving ? SSq : SFinal;
        end
        SSq: if (lane_q == 2'd2) state_q <= SSqrt;
             else lane_q <= lane_q + 2'd1;
        SSqrt:  state_q <= SSqrtW;
        SSqrtW: if (!sts_i.unit_busy) state_q <= SMul;
        SMul: begin
          // friction: gmu, rdt; drag: vv..dt. Zero |v| skips the phase.
          if (sts_i.mag_zero) begin
            if (fric_q) begin
              fric_q <= 1'b0; state_q <= SFricChk;
            end else state_q <= SFinal;
          end else if (fric_q && mul_q == MulGmu) mul_q <= MulRdt;
          else if (fric_q) begin
            mul_q <= MulVV; lane_q <= '0; state_q <= STake;
          end else if (mul_q == MulDt) begin
            mul_q <= MulGmu; state_q <= SDragDiv;
          end else mul_q <= mul_q + 3'd1;
        end
        STake:  state_q <= STakeW;
        STakeW: if (!sts_i.unit_busy) begin
          if (lane_q == 2'd2) begin
            lane_q <= '0;
            if (fric_q) begin
              fric_q <= 1'b0; state_q <= SFricChk;
            end else state_q <= SFinal;
          end else begin
            lane_q <= lane_q + 2'd1; state_q <= STake;
          end
        end
        SDragDiv: state_q <= SDragW;
        SDragW:   if (!sts_i.unit_busy) begin
          lane_q <= '0; state_q <= STake;
        end
        SFinal: begin
          lane_q <= '0;
          state_q <= sts_i.moving ? SPos : SOut;
        end
        SPos: if (lane_q == 2'd2) state_q <= SOut;
              else lane_q <= lane_q + 2'd1;
        SOut: if (!out_stall_i) begin
          state_q <= SIdle; mul_q <= MulGmu;
        end
        default: state_q <= SIdle;
      endcase
    end
  end
endmodule

FILE: rtl/body_force_friction_drag_step.sv
//------------------------------------------------------------------------------
// body_force_friction_drag_step
// Rigid-body step in Q16.16: force, kinetic friction, quadratic drag, then
// position integration, all saturating.
//------------------------------------------------------------------------------
// Time from the accepting edge to result valid is set by the shared
// divide/sqrt unit: three force divides, then up to two roots, up to six
// take-along divides and up to one drag divide.
// One transaction at a time; next input taken the cycle after the result
// handshake.
// Reset clears velocity, position and loads register defaults.
//------------------------------------------------------------------------------
module body_force_friction_drag_step import bffd_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  bffd_in_t             in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output bffd_out_t            out_data_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [RegIdxW-1:0]   cfg_index_i,
  input  logic [31:0]          cfg_data_i
);
  bffd_cfg_t cfg_q;
  bffd_cmd_t cmd;
  bffd_sts_t sts;

  // config writes always taken; unknown index ignored
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{body_mass: MassReset, gravity_accel: GravityReset,
                 kinetic_friction: '0, fluid_density: '0, drag_coeff: '0,
                 frontal_area: '0, stop_threshold: StopThrReset};
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        RegBodyMass:  cfg_q.body_mass        <= cfg_data_i;
        RegGravity:   cfg_q.gravity_accel    <= cfg_data_i;
        RegFriction:  cfg_q.kinetic_friction <= cfg_data_i;
        RegDensity:   cfg_q.fluid_density    <= cfg_data_i;
        RegDragCoeff: cfg_q.drag_coeff       <= cfg_data_i;
        RegArea:      cfg_q.frontal_area     <= cfg_data_i;
        RegStopThr:   cfg_q.stop_threshold   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  bffd_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i,
    .in_stall_o,
    .out_valid_o,
    .out_stall_i,
    .sts_i (sts),
    .cmd_o (cmd)
  );

  bffd_datapath u_dp (
    .clk_i, .rst_ni,
    .cmd_i (cmd),
    .in_i  (in_data_i),
    .cfg_i (cfg_q),
    .sts_o (sts),
    .res_o (out_data_o)
  );
endmodule

FILE: tb/body_force_friction_drag_step_test.sv
`timescale 1ns / 1ps
//------------------------------------------------------------------------------
// body_force_friction_drag_step_test
// Drives force steps through the rigid-body block under random valid and
// stall gaps. A scoreboard keeps its own copy of velocity, position and
// registers, predicts each result and compares it field by field.
//------------------------------------------------------------------------------
module body_force_friction_drag_step_test;
  import bffd_pkg::*;

  localparam longint unsigned SatU = 64'hFFFF_FFFF;
  localparam int unsigned CycleLimit = 8_000_000;

  // ---------------------------------------------------------------------------
  // Scoreboard: own model of the body state, queue of expected results
  // ---------------------------------------------------------------------------
  class body_scoreboard;
    logic [31:0] regs [NumRegs];
    logic signed [31:0] vel [3];
    logic signed [31:0] pos [3];
    bffd_out_t pending_q [$];
    int errors;

    function new();
      errors = 0;
      regs[RegBodyMass] = MassReset;
      regs[RegGravity] = GravityReset;
      regs[RegFriction] = '0;
      regs[RegDensity] = '0;
      regs[RegDragCoeff] = '0;
      regs[RegArea] = '0;
      regs[RegStopThr] = StopThrReset;
      for (int i = 0; i < 3; i++) begin
        vel[i] = '0;
        pos[i] = '0;
      end
    endfunction

    function void write_reg(logic [RegIdxW-1:0] idx, logic [31:0] val);
      if (idx < NumRegs) regs[idx] = val;
    endfunction

    function longint unsigned magn(logic signed [31:0] v);
      longint w;
      w = v;
      return w < 0 ? -w : w;
    endfunction

    function logic signed [31:0] clip(longint v);
      if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
      if (v < -64'sd2147483648) return 32'sh8000_0000;
      return v[31:0];
    endfunction

    function longint unsigned qmul(longint unsigned a, longint unsigned b);
      longint unsigned p;
      p = (a * b) >> 16;
      return p > SatU ? SatU : p;
    endfunction

    function longint unsigned root(longint unsigned n);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > n) b >>= 2;
      while (b != 0) begin
        if (n >= r + b) begin
          n -= r + b;
          r = (r >> 1) + b;
        end else begin
          r >>= 1;
        end
        b >>= 2;
      end
      return r;
    endfunction

    function longint unsigned speed();
      longint unsigned s, m;
      s = 0;
      for (int i = 0; i < 3; i++) begin
        m = magn(vel[i]);
        s += m * m;
      end
      return root(s);
    endfunction

    function bit above_thr();
      for (int i = 0; i < 3; i++)
        if (magn(vel[i]) >= regs[RegStopThr]) return 1'b1;
      return 1'b0;
    endfunction

    // remove amount d along the direction of motion
    function void slow_down(longint unsigned d, longint unsigned sp);
      longint unsigned m;
      longint delta, v;
      for (int i = 0; i < 3; i++) begin
        m = magn(vel[i]);
        delta = longint'((m * d) / sp);
        v = vel[i];
        vel[i] = clip(v < 0 ? v + delta : v - delta);
      end
    endfunction

    function void note_input(bffd_in_t it);
      longint unsigned dt, mass, fm, q, sp, r, t, d;
      longint f, v, p, stp;
      bffd_out_t res;
      logic signed [31:0] frc [3];
      dt = it.step_time;
      mass = regs[RegBodyMass] == 0 ? 1 : regs[RegBodyMass];
      frc[0] = it.force_x;
      frc[1] = it.force_y;
      frc[2] = it.force_z;
      for (int i = 0; i < 3; i++) begin
        f = frc[i];
        fm = f < 0 ? -f : f;
        q = (fm * dt) / mass;
        if (q > (64'd1 << 33)) q = 64'd1 << 33;
        v = vel[i];
        vel[i] = clip(f < 0 ? v - longint'(q) : v + longint'(q));
      end
      if (above_thr()) begin
        sp = speed();
        if (sp != 0) begin
          r = qmul(qmul(regs[RegGravity], regs[RegFriction]), dt);
          if (r > sp) r = sp;
          slow_down(r, sp);
        end
      end
      if (above_thr()) begin
        sp = speed();
        if (sp != 0) begin
          t = qmul(sp, sp);
          t = qmul(t, regs[RegDensity]);
          t = qmul(t, regs[RegDragCoeff]);
          t = qmul(t, regs[RegArea]);
          t >>= 1;
          t = qmul(t, dt);
          d = (t << 16) / mass;
          if (d > SatU) d = SatU;
          slow_down(d, sp);
        end
      end
      if (!above_thr()) begin
        for (int i = 0; i < 3; i++) vel[i] = '0;
        res.moving = 1'b0;
      end else begin
        for (int i = 0; i < 3; i++) begin
          stp = longint'((magn(vel[i]) * dt) >> 16);
          p = pos[i];
          pos[i] = clip(vel[i] < 0 ? p - stp : p + stp);
        end
        res.moving = 1'b1;
      end
      res.pos_x = pos[0];
      res.pos_y = pos[1];
      res.pos_z = pos[2];
      res.vel_x = vel[0];
      res.vel_y = vel[1];
      res.vel_z = vel[2];
      pending_q.push_back(res);
    endfunction

    function void check_result(bffd_out_t got);
      bffd_out_t exp_r;
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        errors++;
        return;
      end
      exp_r = pending_q.pop_front();
      if (got.moving !== exp_r.moving) begin
        $display("%0t: moving exp %0d got %0d", $time, exp_r.moving, got.moving);
        errors++;
      end
      if (got.pos_x !== exp_r.pos_x) begin
        $display("%0t: pos_x exp %0d got %0d", $time, exp_r.pos_x, got.pos_x);
        errors++;
      end
      if (got.pos_y !== exp_r.pos_y) begin
        $display("%0t: pos_y exp %0d got %0d", $time, exp_r.pos_y, got.pos_y);
        errors++;
      end
      if (got.pos_z !== exp_r.pos_z) begin
        $display("%0t: pos_z exp %0d got %0d", $time, exp_r.pos_z, got.pos_z);
        errors++;
      end
      if (got.vel_x !== exp_r.vel_x) begin
        $display("%0t: vel_x exp %0d got %0d", $time, exp_r.vel_x, got.vel_x);
        errors++;
      end
      if (got.vel_y !== exp_r.vel_y) begin
        $display("%0t: vel_y exp %0d got %0d", $time, exp_r.vel_y, got.vel_y);
        errors++;
      end
      if (got.vel_z !== exp_r.vel_z) begin
        $display("%0t: vel_z exp %0d got %0d", $time, exp_r.vel_z, got.vel_z);
        errors++;
      end
    endfunction
  endclass

  // ---------------------------------------------------------------------------
  // DUT and clocking
  // ---------------------------------------------------------------------------
  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  bffd_in_t in_data_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  bffd_out_t out_data_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [RegIdxW-1:0] cfg_index_i = '0;
  logic [31:0] cfg_data_i = '0;

  body_scoreboard sb = new();
  int unsigned cycle_cnt = 0;
  bit calm = 1'b0;      // no idling on either side while set

  body_force_friction_drag_step u_top (.*);

  always #5 clk_i = ~clk_i;

  // Result side: random stall at falling edge, check at rising edge
  always @(negedge clk_i) begin
    if (rst_ni) out_stall_i <= !calm && ($urandom_range(99) < 7);
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CycleLimit) begin
      $display("end of test: mismatches");
      $finish;
    end
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_result(out_data_o);
  end

  // One register write; called only while idle
  task automatic write_reg(input logic [RegIdxW-1:0] idx, input logic [31:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.write_reg(idx, val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // One force transaction; the model is updated at the accepting edge
  task automatic send_step(input bffd_in_t it);
    @(negedge clk_i);
    while (!calm && $urandom_range(99) < 7) @(negedge clk_i);
    in_valid_i <= 1'b1;
    in_data_i <= it;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_input(it);
    @(negedge clk_i);
    in_valid_i <= 1'b0;
  endtask

  // Wait until every expected result is in, then let the block settle
  task automatic drain();
    int unsigned waited;
    waited = 0;
    while (sb.pending_q.size() != 0 && waited < 100000) begin
      @(negedge clk_i);
      waited++;
    end
    repeat (50) @(negedge clk_i);
  endtask

  function automatic logic [31:0] rnd_word();
    case ($urandom_range(5))
      0: return $urandom;
      1: return 32'h8000_0000;
      2: return 32'h7FFF_FFFF;
      3: return 32'hFFFF_FFFF;
      4: return '0;
      default: return $urandom_range(200000);
    endcase
  endfunction

  // Random step: wild picks extreme words, else modest dt and forces around a few units, random signs
  function automatic bffd_in_t rnd_step(input bit wild);
    bffd_in_t it;
    if (wild) begin
      it.step_time = rnd_word();
      it.force_x = rnd_word();
      it.force_y = rnd_word();
      it.force_z = rnd_word();
    end else begin
      it.step_time = $urandom_range(65536, 64);
      it.force_x = $urandom_range(1 << 20) - (1 << 19);
      it.force_y = $urandom_range(1 << 20) - (1 << 19);
      it.force_z = ($urandom_range(3) == 0) ? '0 : $urandom_range(1 << 18) - (1 << 17);
    end
    return it;
  endfunction

  task automatic run_phase(input int n);
    for (int k = 0; k < n; k++) send_step(rnd_step($urandom_range(9) < 2));
    drain();
  endtask

  initial begin
    bffd_in_t it;
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: defaults, extremes, stop, zero threshold, zero mass
    it = '{step_time: 32'h0001_0000, force_x: 32'sh0001_0000, force_y: '0, force_z: '0};
    send_step(it);
    it = '{step_time: '0, force_x: '0, force_y: '0, force_z: '0};
    send_step(it);
    it = '{step_time: 32'hFFFF_FFFF, force_x: 32'sh7FFF_FFFF, force_y: 32'sh8000_0000,
           force_z: 32'sh7FFF_FFFF};
    send_step(it);
    send_step(it);
    it = '{step_time: 32'hFFFF_FFFF, force_x: 32'sh8000_0000, force_y: 32'sh7FFF_FFFF,
           force_z: 32'sh8000_0000};
    send_step(it);
    send_step(it);
    drain();
    // friction strong enough to stop the body
    write_reg(RegFriction, 32'h0001_0000);
    it = '{step_time: 32'h0000_1000, force_x: 32'sh0000_0100, force_y: '0, force_z: '0};
    send_step(it);
    it = '{step_time: 32'h0001_0000, force_x: 32'sh0004_0000, force_y: -32'sh0003_0000,
           force_z: 32'sh0000_8000};
    send_step(it);
    drain();
    // zero threshold, zero mass, heavy drag
    write_reg(RegStopThr, '0);
    write_reg(RegBodyMass, '0);
    write_reg(RegDensity, 32'hFFFF_FFFF);
    write_reg(RegDragCoeff, 32'hFFFF_FFFF);
    write_reg(RegArea, 32'hFFFF_FFFF);
    write_reg(RegGravity, 32'hFFFF_FFFF);
    write_reg(RegFriction, '0);
    it = '{step_time: '0, force_x: '0, force_y: '0, force_z: '0};
    send_step(it);
    it = '{step_time: 32'h0000_0001, force_x: 32'sh0000_0001, force_y: -32'sh0000_0001,
           force_z: '0};
    send_step(it);
    send_step(rnd_step(1'b1));
    drain();
    write_reg(RegStopThr, 32'hFFFF_FFFF);
    write_reg(RegBodyMass, 32'hFFFF_FFFF);
    send_step(rnd_step(1'b1));
    send_step(rnd_step(1'b0));
    drain();

    // Random phases, each with its own register setting
    for (int ph = 0; ph < 13; ph++) begin
      calm = (ph == 4);
      case (ph % 4)
        0: begin
          write_reg(RegBodyMass, $urandom_range(1 << 20, 1 << 14));
          write_reg(RegGravity, GravityReset);
          write_reg(RegFriction, $urandom_range(1 << 15));
          write_reg(RegDensity, $urandom_range(1 << 17));
          write_reg(RegDragCoeff, $urandom_range(1 << 16));
          write_reg(RegArea, $urandom_range(1 << 17));
          write_reg(RegStopThr, $urandom_range(2000));
        end
        1: begin
          write_reg(RegBodyMass, rnd_word());
          write_reg(RegFriction, '0);
          write_reg(RegDensity, '0);
          write_reg(RegStopThr, StopThrReset);
        end
        2: begin
          write_reg(RegBodyMass, $urandom_range(1 << 18, 1));
          write_reg(RegGravity, rnd_word());
          write_reg(RegFriction, rnd_word());
          write_reg(RegDensity, rnd_word());
          write_reg(RegDragCoeff, rnd_word());
          write_reg(RegArea, rnd_word());
          write_reg(RegStopThr, rnd_word());
        end
        default: begin
          write_reg(RegBodyMass, 32'h0001_0000);
          write_reg(RegGravity, GravityReset);
          write_reg(RegFriction, $urandom_range(1 << 14));
          write_reg(RegDensity, 32'h0001_0000);
          write_reg(RegDragCoeff, 32'h0000_8000);
          write_reg(RegArea, 32'h0001_0000);
          write_reg(RegStopThr, ($urandom_range(1)) ? '0 : StopThrReset);
        end
      endcase
      run_phase(150);
    end
    calm = 1'b0;

    if (sb.errors == 0 && sb.pending_q.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/bffd_pkg.sv
rtl/bffd_divsqrt.sv
rtl/bffd_datapath.sv
rtl/bffd_ctrl.sv
rtl/body_force_friction_drag_step.sv
tb/body_force_friction_drag_step_test.sv
